// ===== design/gbfs_pkg.sv =====
// Package for the glyph box-filter scaler: shared constants, register indexes
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package gbfs_pkg;

	// Item opcodes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_ONLY  = 2'd2;

	// Cell size handling
	localparam int CELL_W = 7;
	localparam logic [CELL_W-1:0] DEF_CELL_WIDTH  = 7'd8;
	localparam logic [CELL_W-1:0] DEF_CELL_HEIGHT = 7'd12;
	localparam logic [CELL_W-1:0] MAX_CELL        = 7'd64;
	localparam int MAX_CELL_INT = 64;

	// Code remap and block graphics range
	localparam logic [7:0] REMAP_LIMIT  = 8'h20;
	localparam logic [7:0] REMAP_OFFSET = 8'h40;
	localparam logic [7:0] GFX_FIRST    = 8'd128;
	localparam logic [7:0] GFX_LAST     = 8'd191;

	// x/3 for x <= 64 as (x * THIRD_MUL) >> THIRD_SHIFT
	localparam int THIRD_MUL_W = 14;
	localparam logic [THIRD_MUL_W-1:0] THIRD_MUL = 14'd171;
	localparam int THIRD_SHIFT = 9;

	typedef struct packed {
		logic latch;   // take the input beat into the working registers
		logic setup;   // resolve cell size, code remap and store base
		logic prep;    // per-query overlap lanes and block graphics
		logic write;   // write the glyph row of a load
		logic scan;    // read and weigh one source row
		logic emit;    // load the result register
	} cmd_t;

	typedef struct packed {
		logic is_query;  // working item is a pixel query
		logic direct;    // query needs no scan (outside cell or block graphics)
		logic last_row;  // scan is on the final source row
	} sts_t;

endpackage

// ===== design/gbfs_ctrl.sv =====
// Controller for the glyph box-filter scaler: sequences one item through
// setup, a glyph row write or a row scan, and result hand-off. Depends on gbfs_pkg.
`timescale 1ns / 1ps

module gbfs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  gbfs_pkg::sts_t sts,
	output gbfs_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_PREP,
		ST_WRITE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.latch = (state_q == ST_IDLE) && in_valid;
		cmd.setup = (state_q == ST_SETUP);
		cmd.prep  = (state_q == ST_PREP);
		cmd.write = (state_q == ST_WRITE);
		cmd.scan  = (state_q == ST_SCAN);
		cmd.emit  = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= sts.is_query ? ST_PREP : ST_WRITE;
				end
				ST_PREP: begin
					state_q <= sts.direct ? ST_DONE : ST_SCAN;
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (sts.last_row) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// last row read is still being weighed
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/gbfs_datapath.sv =====
// Datapath for the glyph box-filter scaler: configuration registers, glyph
// store, overlap lanes, row accumulator and result register.
// Depends on gbfs_pkg; driven by gbfs_ctrl commands.
`timescale 1ns / 1ps

module gbfs_datapath #(
	parameter int SRC_WIDTH  = 8,
	parameter int SRC_HEIGHT = 12,
	parameter int ROM_ROWS   = 12,
	parameter int CHAR_COUNT = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gbfs_pkg::cmd_t                cmd,
	output gbfs_pkg::sts_t                sts,
	input  logic                          cfg_we,
	input  logic [gbfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          opcode,
	input  logic [7:0]                    char_code,
	input  logic [3:0]                    row_index,
	input  logic [7:0]                    row_bits,
	input  logic [5:0]                    dest_x,
	input  logic [5:0]                    dest_y,
	output logic                          ink,
	output logic                          was_query
);

	localparam int DEPTH  = CHAR_COUNT * ROM_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int X_W    = $clog2(gbfs_pkg::MAX_CELL_INT * SRC_WIDTH + 1);
	localparam int Y_W    = $clog2(gbfs_pkg::MAX_CELL_INT * SRC_HEIGHT + 1);
	localparam int SY_W   = $clog2(SRC_HEIGHT + 1);
	localparam int HOV_W  = $clog2(SRC_WIDTH + 1);
	localparam int VOV_W  = $clog2(SRC_HEIGHT + 1);
	localparam int AREA   = SRC_WIDTH * SRC_HEIGHT;
	localparam int COV_W  = $clog2(AREA + 1);
	localparam int CMP_W  = COV_W + 1;
	localparam int CODE_W = 9;
	localparam int ROW_W  = 5;

	// Configuration registers
	logic [gbfs_pkg::CELL_W-1:0] cell_width_q;
	logic [gbfs_pkg::CELL_W-1:0] cell_height_q;
	logic                        upper_only_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q  <= gbfs_pkg::DEF_CELL_WIDTH;
			cell_height_q <= gbfs_pkg::DEF_CELL_HEIGHT;
			upper_only_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gbfs_pkg::CFG_CELL_WIDTH:  cell_width_q  <= cfg_data[gbfs_pkg::CELL_W-1:0];
				gbfs_pkg::CFG_CELL_HEIGHT: cell_height_q <= cfg_data[gbfs_pkg::CELL_W-1:0];
				gbfs_pkg::CFG_UPPER_ONLY:  upper_only_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Working copy of the accepted beat
	logic       opcode_q;
	logic [7:0] code_q;
	logic [3:0] row_q;
	logic [7:0] bits_q;
	logic [5:0] dx_q;
	logic [5:0] dy_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			opcode_q <= opcode;
			code_q   <= char_code;
			row_q    <= row_index;
			bits_q   <= row_bits;
			dx_q     <= dest_x;
			dy_q     <= dest_y;
		end
	end

	// Setup: effective cell size, remapped code, store base
	logic [gbfs_pkg::CELL_W-1:0] cw_c, ch_c;
	logic [7:0]                  code_c;
	logic [gbfs_pkg::CELL_W-1:0] cw_s, ch_s;
	logic [7:0]                  code_s;
	logic [ADDR_W-1:0]           base_q;
	logic                        code_ok_q;

	always_comb begin
		cw_c = cell_width_q;
		ch_c = cell_height_q;
		if (cw_c == '0 || ch_c == '0) begin
			cw_c = gbfs_pkg::DEF_CELL_WIDTH;
			ch_c = gbfs_pkg::DEF_CELL_HEIGHT;
		end
		if (cw_c > gbfs_pkg::MAX_CELL) begin
			cw_c = gbfs_pkg::MAX_CELL;
		end
		if (ch_c > gbfs_pkg::MAX_CELL) begin
			ch_c = gbfs_pkg::MAX_CELL;
		end
		code_c = code_q;
		if (opcode_q == gbfs_pkg::OP_QUERY && upper_only_q && code_q < gbfs_pkg::REMAP_LIMIT) begin
			code_c = code_q + gbfs_pkg::REMAP_OFFSET;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			cw_s      <= cw_c;
			ch_s      <= ch_c;
			code_s    <= code_c;
			base_q    <= ADDR_W'(code_c) * ADDR_W'(ROM_ROWS);
			code_ok_q <= {1'b0, code_c} < CODE_W'(CHAR_COUNT);
		end
	end

	// Prep: horizontal overlap per source column, vertical window, block graphics
	logic [X_W-1:0]   x_lo_c, x_hi_c;
	logic [HOV_W-1:0] hov_c [SRC_WIDTH];
	logic [HOV_W-1:0] hov_q [SRC_WIDTH];
	logic [Y_W-1:0]   ylo_q, yhi_q;
	logic             in_cell_c, gfx_c, blk_c;
	logic             in_cell_q, gfx_q, blk_q;
	logic [gbfs_pkg::THIRD_MUL_W-1:0] third_prod;
	logic [5:0]       upper_y, lower_y, mid_x;
	logic [1:0]       band;
	logic [2:0]       bit_sel;

	assign x_lo_c = X_W'(dx_q) * X_W'(SRC_WIDTH);
	assign x_hi_c = X_W'({1'b0, dx_q} + 7'd1) * X_W'(SRC_WIDTH);

	for (genvar sx = 0; sx < SRC_WIDTH; sx++) begin : g_lane
		logic [X_W-1:0] lft, rgt;
		always_comb begin
			lft = X_W'(cw_s) * X_W'(sx);
			rgt = X_W'(cw_s) * X_W'(sx + 1);
			if (x_lo_c > lft) begin
				lft = x_lo_c;
			end
			if (x_hi_c < rgt) begin
				rgt = x_hi_c;
			end
			hov_c[sx] = (rgt > lft) ? HOV_W'(rgt - lft) : '0;
		end
	end

	always_comb begin
		in_cell_c  = ({1'b0, dx_q} < cw_s) && ({1'b0, dy_q} < ch_s);
		gfx_c      = (code_s >= gbfs_pkg::GFX_FIRST) && (code_s <= gbfs_pkg::GFX_LAST);
		third_prod = gbfs_pkg::THIRD_MUL_W'(ch_s) * gbfs_pkg::THIRD_MUL;
		upper_y    = 6'(third_prod >> gbfs_pkg::THIRD_SHIFT);
		lower_y    = 6'({upper_y, 1'b0});
		mid_x      = 6'(cw_s >> 1);
		if (dy_q < upper_y) begin
			band = 2'd0;
		end else if (dy_q < lower_y) begin
			band = 2'd1;
		end else begin
			band = 2'd2;
		end
		bit_sel = {band, 1'b0} + {2'b00, (dx_q >= mid_x)};
		blk_c   = code_s[bit_sel];
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			hov_q     <= hov_c;
			ylo_q     <= Y_W'(dy_q) * Y_W'(SRC_HEIGHT);
			yhi_q     <= Y_W'({1'b0, dy_q} + 7'd1) * Y_W'(SRC_HEIGHT);
			in_cell_q <= in_cell_c;
			gfx_q     <= gfx_c;
			blk_q     <= blk_c;
		end
	end

	// Glyph store
	logic [7:0] store [DEPTH];
	logic [7:0] rd_data_q;
	logic       row_ok_c;
	logic       wr_ok;
	logic [SY_W-1:0] sy_q;

	assign wr_ok    = code_ok_q && ({1'b0, row_q} < ROW_W'(ROM_ROWS));
	assign row_ok_c = code_ok_q && (ROW_W'(sy_q) < ROW_W'(ROM_ROWS));

	always_ff @(posedge clk) begin
		if (cmd.write && wr_ok) begin
			store[base_q + ADDR_W'(row_q)] <= bits_q;
		end
		if (cmd.scan && row_ok_c) begin
			rd_data_q <= store[base_q + ADDR_W'(sy_q)];
		end
	end

	// Row scan: vertical overlap of the current source row
	logic [Y_W-1:0]   ytop_q;
	logic [Y_W-1:0]   top_c, bot_c;
	logic [VOV_W-1:0] vov_c;
	logic [VOV_W-1:0] vov_s1;
	logic             row_ok_s1;
	logic             acc_en_s1;

	always_comb begin
		top_c = ytop_q;
		bot_c = Y_W'(ytop_q + Y_W'(ch_s));
		if (ylo_q > top_c) begin
			top_c = ylo_q;
		end
		if (yhi_q < bot_c) begin
			bot_c = yhi_q;
		end
		vov_c = (bot_c > top_c) ? VOV_W'(bot_c - top_c) : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			sy_q   <= '0;
			ytop_q <= '0;
		end else if (cmd.scan) begin
			sy_q   <= SY_W'(sy_q + 1'b1);
			ytop_q <= Y_W'(ytop_q + Y_W'(ch_s));
		end
		if (cmd.scan) begin
			vov_s1    <= vov_c;
			row_ok_s1 <= row_ok_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= cmd.scan;
		end
	end

	// Weigh the row read last cycle and accumulate the covered area
	logic [7:0]       row_px;
	logic [HOV_W-1:0] row_sum;
	logic [COV_W-1:0] covered_q;

	always_comb begin
		row_px  = row_ok_s1 ? rd_data_q : 8'd0;
		row_sum = '0;
		for (int sx = 0; sx < SRC_WIDTH; sx++) begin
			if (row_px[sx]) begin
				row_sum = HOV_W'(row_sum + hov_q[sx]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			covered_q <= '0;
		end else if (acc_en_s1) begin
			covered_q <= COV_W'(covered_q + COV_W'(COV_W'(row_sum) * COV_W'(vov_s1)));
		end
	end

	// Result register
	logic ink_q, was_query_q;
	logic box_ink;

	assign box_ink = {covered_q, 1'b0} >= CMP_W'(AREA);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			was_query_q <= opcode_q;
			ink_q       <= opcode_q && in_cell_q && (gfx_q ? blk_q : box_ink);
		end
	end

	assign ink       = ink_q;
	assign was_query = was_query_q;

	always_comb begin
		sts          = '0;
		sts.is_query = (opcode_q == gbfs_pkg::OP_QUERY);
		sts.direct   = !in_cell_c || gfx_c;
		sts.last_row = (sy_q == SY_W'(SRC_HEIGHT - 1));
	end

endmodule

// ===== design/glyph_box_filter_scaler_unit.sv =====
// Glyph box-filter scaler, top level: joins controller and datapath.
// Usage: in_valid/in_stall carries items (opcode 0 loads one glyph row,
// opcode 1 queries one destination pixel); out_valid/out_stall returns one
// result beat (ink, was_query) per item; cfg_valid/cfg_ready writes
// cell_width (0), cell_height (1) and uppercase_only_model (2).
// One item is worked at a time. A load passes setup and the glyph row write
// before its result is registered. A box-filtered query reads its SRC_HEIGHT
// glyph rows one per cycle from the single-port glyph store and weighs the
// last row in a drain state; block graphics and pixels outside the cell
// skip the scan.
// Reset clears the controller, empties the result register and sets the
// cell to 8 x 12; the glyph store is not cleared and must be loaded before
// its rows are queried. While out_stall is high the finished result holds
// in the output register and the item in progress waits for it to drain;
// a result already waiting does not keep the next item from being accepted.
// Write configuration only while no item is in progress.
`timescale 1ns / 1ps

module glyph_box_filter_scaler_unit #(
	parameter int SRC_WIDTH  = 8,
	parameter int SRC_HEIGHT = 12,
	parameter int ROM_ROWS   = 12,
	parameter int CHAR_COUNT = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           opcode,
	input  logic [7:0]                     char_code,
	input  logic [3:0]                     row_index,
	input  logic [7:0]                     row_bits,
	input  logic [5:0]                     dest_x,
	input  logic [5:0]                     dest_y,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           ink,
	output logic                           was_query,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gbfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	gbfs_pkg::cmd_t cmd;
	gbfs_pkg::sts_t sts;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	gbfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	gbfs_datapath #(
		.SRC_WIDTH  (SRC_WIDTH),
		.SRC_HEIGHT (SRC_HEIGHT),
		.ROM_ROWS   (ROM_ROWS),
		.CHAR_COUNT (CHAR_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.opcode    (opcode),
		.char_code (char_code),
		.row_index (row_index),
		.row_bits  (row_bits),
		.dest_x    (dest_x),
		.dest_y    (dest_y),
		.ink       (ink),
		.was_query (was_query)
	);

endmodule

// ===== tb/glyph_box_filter_scaler_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for glyph_box_filter_scaler_unit: glyph row loads and
// pixel queries go in, each result beat is predicted and compared per field.
// Depends on gbfs_pkg and the scaler RTL only.

module glyph_box_filter_scaler_unit_tb;
	import gbfs_pkg::*;

	localparam int SRC_W        = 8;
	localparam int SRC_H        = 12;
	localparam int ROM_ROWS     = 12;
	localparam int CHAR_COUNT   = 256;
	localparam int POOL_SIZE    = 16;
	// Glyphs kept fully loaded so the random queries never hit an unwritten row
	localparam logic [POOL_SIZE*8-1:0] GLYPH_POOL = {
		8'h00, 8'h05, 8'h1F, 8'h20, 8'h2A, 8'h3F, 8'h40, 8'h41,
		8'h45, 8'h5F, 8'h60, 8'h7F, 8'hC0, 8'hD5, 8'hFE, 8'hFF};
	localparam int N_PHASES     = 10;
	localparam int PHASE_ITEMS  = 140;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic       op;
		logic [7:0] code;
		logic [3:0] row;
		logic [7:0] bits;
		logic [5:0] dx;
		logic [5:0] dy;
	} glyph_item_t;

	typedef struct packed {
		bit          is_cfg;
		logic [6:0]  cfg_w;
		logic [6:0]  cfg_h;
		logic        cfg_u;
		glyph_item_t item;
		bit          typed;
		bit          typed_ink;
	} directed_step_t;

	typedef struct packed {
		bit ink;
		bit was_query;
		int seq;
	} pixel_result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic                 opcode    = OP_LOAD;
	logic [7:0]           char_code = '0;
	logic [3:0]           row_index = '0;
	logic [7:0]           row_bits  = '0;
	logic [5:0]           dest_x    = '0;
	logic [5:0]           dest_y    = '0;
	logic                 out_valid;
	logic                 out_stall;
	logic                 ink;
	logic                 was_query;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_CELL_WIDTH;
	logic [31:0]          cfg_data  = '0;

	logic rx_wait  = 1'b0;
	logic rx_hold  = 1'b0;
	logic hold_req = 1'b0;
	bit   calm_tx  = 1'b0;
	bit   calm_rx  = 1'b0;

	// Predictor state
	bit [7:0]          glyph_mem [CHAR_COUNT*ROM_ROWS];
	bit [ROM_ROWS-1:0] rows_written [CHAR_COUNT];
	logic [6:0]        cell_w_q     = DEF_CELL_WIDTH;
	logic [6:0]        cell_h_q     = DEF_CELL_HEIGHT;
	logic              upper_only_q = 1'b0;

	pixel_result_t  pixel_expect_q [$];
	directed_step_t directed_steps [$];

	int mismatches  = 0;
	int items_sent  = 0;
	int n_loads     = 0;
	int n_queries   = 0;
	int n_inked     = 0;
	int n_outside   = 0;
	int n_settings  = 0;
	int cycle_count = 0;

	assign out_stall = rx_wait | rx_hold;

	always #1 clk = ~clk;

	glyph_box_filter_scaler_unit #(
		.SRC_WIDTH (SRC_W),
		.SRC_HEIGHT(SRC_H),
		.ROM_ROWS  (ROM_ROWS),
		.CHAR_COUNT(CHAR_COUNT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.char_code(char_code),
		.row_index(row_index),
		.row_bits (row_bits),
		.dest_x   (dest_x),
		.dest_y   (dest_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ink      (ink),
		.was_query(was_query),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	task automatic flag_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// Zero size falls back to the default cell, oversize saturates
	function automatic void cell_dims(output int cw, output int ch);
		cw = cell_w_q;
		ch = cell_h_q;
		if (cw == 0 || ch == 0) begin
			cw = DEF_CELL_WIDTH;
			ch = DEF_CELL_HEIGHT;
		end
		if (cw > MAX_CELL_INT) cw = MAX_CELL_INT;
		if (ch > MAX_CELL_INT) ch = MAX_CELL_INT;
	endfunction

	function automatic logic [7:0] remap_code(logic [7:0] code);
		return (upper_only_q && code < REMAP_LIMIT) ? code + REMAP_OFFSET : code;
	endfunction

	function automatic bit query_ok(logic [7:0] code);
		logic [7:0] c;
		c = remap_code(code);
		return (c >= GFX_FIRST && c <= GFX_LAST) || (&rows_written[c]);
	endfunction

	function automatic bit predict_ink(glyph_item_t it);
		int cw, ch, band, half, x_lo, y_lo, top, bot, lft, rgt, area, sy, sx;
		logic [7:0] code, rowv;
		cell_dims(cw, ch);
		code = remap_code(it.code);
		area = 0;
		if (it.dx >= cw || it.dy >= ch) return 1'b0;
		if (code >= GFX_FIRST && code <= GFX_LAST) begin
			band = (it.dy < ch / 3) ? 0 : ((it.dy < ch / 3 * 2) ? 1 : 2);
			half = (it.dx < cw / 2) ? 0 : 1;
			return code[band * 2 + half];
		end
		if (int'(code) >= CHAR_COUNT) return 1'b0;
		x_lo = it.dx * SRC_W;
		y_lo = it.dy * SRC_H;
		// Exact overlap of the destination pixel with each inked source pixel
		for (sy = 0; sy < SRC_H; sy++) begin
			top = (sy * ch > y_lo) ? sy * ch : y_lo;
			bot = ((sy + 1) * ch < y_lo + SRC_H) ? (sy + 1) * ch : y_lo + SRC_H;
			if (bot > top && sy < ROM_ROWS) begin
				rowv = glyph_mem[int'(code) * ROM_ROWS + sy];
				for (sx = 0; sx < SRC_W; sx++) begin
					if (rowv[sx]) begin
						lft = (sx * cw > x_lo) ? sx * cw : x_lo;
						rgt = ((sx + 1) * cw < x_lo + SRC_W) ? (sx + 1) * cw : x_lo + SRC_W;
						if (rgt > lft) area += (rgt - lft) * (bot - top);
					end
				end
			end
		end
		return (2 * area >= SRC_W * SRC_H);
	endfunction

	// Offer one beat after a random gap; predict and queue the result on accept
	task automatic send_item(glyph_item_t it, bit typed, bit typed_ink);
		int gap, cw, ch;
		pixel_result_t want;
		gap = calm_tx ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= it.op;
		char_code <= it.code;
		row_index <= it.row;
		row_bits  <= it.bits;
		dest_x    <= it.dx;
		dest_y    <= it.dy;
		do @(posedge clk); while (in_stall !== 1'b0);
		items_sent++;
		want.seq = items_sent;
		want.was_query = (it.op == OP_QUERY);
		if (it.op == OP_LOAD) begin
			if (int'(it.code) < CHAR_COUNT && it.row < ROM_ROWS) begin
				glyph_mem[int'(it.code) * ROM_ROWS + it.row] = it.bits;
				rows_written[it.code][it.row] = 1'b1;
			end
			want.ink = 1'b0;
			n_loads++;
		end else begin
			cell_dims(cw, ch);
			want.ink = predict_ink(it);
			n_queries++;
			if (it.dx >= cw || it.dy >= ch) n_outside++;
		end
		if (typed) want.ink = typed_ink;
		n_inked += want.ink;
		pixel_expect_q.push_back(want);
	endtask

	// Leaves cfg_valid high; the caller drops it after the last beat
	task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
	endtask

	task automatic write_cell_config(logic [6:0] w, logic [6:0] h, logic u);
		in_valid <= 1'b0;
		while (pixel_expect_q.size() != 0) @(posedge clk);
		cfg_beat(CFG_CELL_WIDTH, {25'd0, w});
		cell_w_q = w;
		cfg_beat(CFG_CELL_HEIGHT, {25'd0, h});
		cell_h_q = h;
		cfg_beat(CFG_UPPER_ONLY, {31'd0, u});
		upper_only_q = u;
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic add_item(logic op, logic [7:0] code, logic [3:0] row, logic [7:0] bits,
			logic [5:0] dx, logic [5:0] dy, bit typed, bit typed_ink);
		directed_step_t s;
		s = '0;
		s.item = '{op: op, code: code, row: row, bits: bits, dx: dx, dy: dy};
		s.typed = typed;
		s.typed_ink = typed_ink;
		directed_steps.push_back(s);
	endtask

	task automatic add_cfg(logic [6:0] w, logic [6:0] h, logic u);
		directed_step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.cfg_w = w;
		s.cfg_h = h;
		s.cfg_u = u;
		directed_steps.push_back(s);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				pixel_expect_q.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : result_sink
		pixel_result_t want;
		int n;
		forever begin
			n = calm_rx ? 0 : $urandom_range(0, 11);
			if (n != 0) begin
				rx_wait <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rx_wait <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1 || out_stall !== 1'b0);
			if (pixel_expect_q.size() == 0) begin
				flag_mismatch($sformatf("result beat with nothing pending (ink=%b was_query=%b)",
					ink, was_query));
			end else begin
				want = pixel_expect_q.pop_front();
				if (ink !== want.ink)
					flag_mismatch($sformatf("item %0d: ink %b, want %b", want.seq, ink, want.ink));
				if (was_query !== want.was_query)
					flag_mismatch($sformatf("item %0d: was_query %b, want %b", want.seq,
						was_query, want.was_query));
			end
		end
	end

	// Back-pressure burst: hold the output long enough to fill the block
	initial begin : long_hold
		do @(posedge clk); while (!hold_req);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin : stimulus
		glyph_item_t it;
		logic [6:0]  ph_w [N_PHASES];
		logic [6:0]  ph_h [N_PHASES];
		logic        ph_u [N_PHASES];
		int          p, i, c, r, k, sel, cw, ch;

		// Glyph at 0x41: row 0 inks the leftmost pixel, row 11 the rightmost,
		// at 8 x 12 every destination pixel maps onto one source pixel
		for (r = 0; r < ROM_ROWS; r++)
			add_item(OP_LOAD, 8'h41, r, (r == 0) ? 8'h01 : ((r == 11) ? 8'h80 : 8'h3C),
				6'd0, 6'd0, 1'b1, 1'b0);
		add_item(OP_LOAD, 8'hFF, 4'hF, 8'hFF, 6'h3F, 6'h3F, 1'b1, 1'b0);  // row past store
		add_item(OP_LOAD, 8'h00, 4'd12, 8'h00, 6'd0, 6'd0, 1'b1, 1'b0);
		add_item(OP_QUERY, 8'h41, 4'd0, 8'h00, 6'd0, 6'd0, 1'b1, 1'b1);
		add_item(OP_QUERY, 8'h41, 4'd0, 8'h00, 6'd7, 6'd11, 1'b1, 1'b1);
		add_item(OP_QUERY, 8'h41, 4'd0, 8'h00, 6'd1, 6'd0, 1'b1, 1'b0);
		add_item(OP_QUERY, 8'h41, 4'd0, 8'h00, 6'd2, 6'd5, 1'b1, 1'b1);
		add_item(OP_QUERY, 8'h41, 4'd0, 8'h00, 6'd8, 6'd0, 1'b1, 1'b0);    // outside cell
		add_item(OP_QUERY, 8'h41, 4'hF, 8'hFF, 6'h3F, 6'h3F, 1'b1, 1'b0);
		add_item(OP_QUERY, 8'h80, 4'd0, 8'h00, 6'd0, 6'd0, 1'b1, 1'b0);    // empty blocks
		add_item(OP_QUERY, 8'hBF, 4'd0, 8'h00, 6'd7, 6'd11, 1'b1, 1'b1);   // full blocks
		// Zero width falls back to 8 x 12; low codes remap onto 0x41
		add_cfg(7'd0, 7'd20, 1'b1);
		add_item(OP_QUERY, 8'h01, 4'd0, 8'h00, 6'd0, 6'd0, 1'b1, 1'b1);
		add_item(OP_QUERY, 8'h01, 4'd0, 8'h00, 6'd7, 6'd11, 1'b1, 1'b1);
		// Oversized cell saturates to 64 x 64
		add_cfg(7'd127, 7'd127, 1'b0);
		add_item(OP_QUERY, 8'h41, 4'd0, 8'h00, 6'd63, 6'd63, 1'b0, 1'b0);
		add_item(OP_QUERY, 8'h9C, 4'd0, 8'h00, 6'd40, 6'd30, 1'b0, 1'b0);
		add_item(OP_QUERY, 8'h41, 4'd0, 8'h00, 6'd31, 6'd0, 1'b0, 1'b0);

		ph_w[0] = 7'd1;   ph_h[0] = 7'd1;   ph_u[0] = 1'b0;
		ph_w[1] = 7'd64;  ph_h[1] = 7'd64;  ph_u[1] = 1'b1;
		ph_w[2] = 7'd0;   ph_h[2] = 7'd33;  ph_u[2] = 1'b1;
		ph_w[3] = 7'd127; ph_h[3] = 7'd100; ph_u[3] = 1'b0;
		ph_w[4] = 7'd8;   ph_h[4] = 7'd12;  ph_u[4] = 1'b0;
		ph_w[5] = 7'd5;   ph_h[5] = 7'd7;   ph_u[5] = 1'b1;
		ph_w[6] = 7'd2;   ph_h[6] = 7'd64;  ph_u[6] = 1'b0;
		ph_w[7] = 7'd64;  ph_h[7] = 7'd1;   ph_u[7] = 1'b1;
		for (p = 8; p < N_PHASES; p++) begin
			ph_w[p] = $urandom_range(1, MAX_CELL_INT);
			ph_h[p] = $urandom_range(1, MAX_CELL_INT);
			ph_u[p] = $urandom_range(0, 1);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_steps[i]) begin
			if (directed_steps[i].is_cfg)
				write_cell_config(directed_steps[i].cfg_w, directed_steps[i].cfg_h,
					directed_steps[i].cfg_u);
			else
				send_item(directed_steps[i].item, directed_steps[i].typed,
					directed_steps[i].typed_ink);
		end

		// Fill the pool glyphs with random rows
		for (c = 0; c < POOL_SIZE; c++) begin
			for (r = 0; r < ROM_ROWS; r++) begin
				it = '0;
				it.op = OP_LOAD;
				it.code = GLYPH_POOL[c*8 +: 8];
				it.row = r;
				it.bits = $urandom;
				it.dx = $urandom;
				it.dy = $urandom;
				send_item(it, 1'b0, 1'b0);
			end
		end

		for (p = 0; p < N_PHASES; p++) begin
			write_cell_config(ph_w[p], ph_h[p], ph_u[p]);
			calm_tx = (p == 4 || p == 5 || p == 7);
			calm_rx = (p == 4 || p == 7);
			if (p == 5) hold_req <= 1'b1;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				it = '0;
				it.bits = $urandom;
				it.dx = $urandom;
				it.dy = $urandom;
				if ($urandom_range(0, 3) == 0) begin
					it.op = OP_LOAD;
					k = $urandom_range(0, POOL_SIZE - 1);
					it.code = ($urandom_range(0, 9) < 7) ? GLYPH_POOL[k*8 +: 8] : $urandom_range(0, 255);
					it.row = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 15)
						: $urandom_range(0, ROM_ROWS - 1);
				end else begin
					it.op = OP_QUERY;
					it.row = $urandom;
					sel = $urandom_range(0, 9);
					if (sel < 2) begin
						it.code = $urandom_range(GFX_FIRST, GFX_LAST);
					end else if (sel == 2) begin
						it.code = $urandom_range(0, 255);
					end else begin
						k = $urandom_range(0, POOL_SIZE - 1);
						it.code = GLYPH_POOL[k*8 +: 8];
						// Reach remapped glyphs through their low alias
						if (upper_only_q && it.code >= REMAP_OFFSET
								&& it.code < REMAP_OFFSET + REMAP_LIMIT && $urandom_range(0, 1))
							it.code = it.code - REMAP_OFFSET;
					end
					if (!query_ok(it.code)) it.code = $urandom_range(GFX_FIRST, GFX_LAST);
					cell_dims(cw, ch);
					if ($urandom_range(0, 3) != 0) begin
						it.dx = $urandom_range(0, cw - 1);
						it.dy = $urandom_range(0, ch - 1);
					end
				end
				send_item(it, 1'b0, 1'b0);
			end
		end

		in_valid <= 1'b0;
		while (pixel_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d glyph row loads and %0d pixel queries across %0d cell settings.",
			n_loads, n_queries, n_settings);
		$display("%0d results inked, %0d queries outside the cell, %0d mismatches.",
			n_inked, n_outside, mismatches);
		if (mismatches == 0 && pixel_expect_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
